// ----- design/a_star_graph_path_search_core_assert.svh -----
// assertion macros for the a* path search core
// expects clk and rst_n in the scope where a macro is used
`ifndef A_STAR_GRAPH_PATH_SEARCH_CORE_ASSERT_SVH
`define A_STAR_GRAPH_PATH_SEARCH_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ASTAR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ASTAR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/astar_pkg.sv -----
// shared types and constants for the a* path search core
// no dependencies
`timescale 1ns / 1ps

package astar_pkg;

  localparam int NODE_FW = 6;
  localparam int COST_W  = 23;
  localparam int EST_W   = 22;
  localparam int KEY_W   = 24;
  localparam int RESULT_LIMIT = 64;

  localparam logic [COST_W-1:0] COST_INF = 23'h7FFFFF;

  localparam logic [1:0] ACT_ADD_EDGE = 2'd0;
  localparam logic [1:0] ACT_SET_EST  = 2'd1;
  localparam logic [1:0] ACT_SEARCH   = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [NODE_FW-1:0] node_a;
    logic [NODE_FW-1:0] node_b;
    logic [15:0]        weight;
    logic [EST_W-1:0]   estimate;
  } in_item_t;

  typedef struct packed {
    logic [NODE_FW-1:0] path_node;
    logic               found;
    logic               last;
  } out_item_t;

endpackage

// ----- design/astar_ram.sv -----
// generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module astar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/a_star_graph_path_search_core.sv -----
// a* shortest path search core: graph store, sequencer and path output
// depends on astar_pkg, astar_ram and a_star_graph_path_search_core_assert.svh
`timescale 1ns / 1ps
//
// Usage: an input word is taken when start is high and busy is low.
// action add edge stores (node_a, node_b, weight) as an undirected edge and
// action set estimate stores the heuristic of node_a; both leave busy low,
// so load words may follow every cycle. Edges past the table capacity are
// dropped. action run search raises busy until the whole path has been
// sent on the result port, start node first, last set on the goal.
// An unreachable or out of range start/goal gives one word with found low.
// Results appear on out_data for one cycle each with out_valid high; the
// receiver cannot stall, so path words leave back to back.
// Search steps: clear the node state of the node_count nodes (clamped to
// MAX_NODES), then for each closed node a key scan through the one shared
// add/compare unit, a read of every stored edge and a node state read for
// each edge that touches the closed node (one node state ram port is the
// limit), then a parent walk into the path buffer and an emit of the path
// words, the goal word leaving as busy falls.
// cfg_we/cfg_wdata write node_count at any edge; write it only while idle.
// Reset (synchronous, rst_n low) empties the edge table and sets node_count
// to 64; estimates are undefined until written.

module a_star_graph_path_search_core #(
  parameter int MAX_NODES   = 64,
  parameter int MAX_EDGES   = 256,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  astar_pkg::in_item_t  in_data,
  output logic                 out_valid,
  output astar_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [6:0]           cfg_wdata
);

  import astar_pkg::*;

`include "a_star_graph_path_search_core_assert.svh"

  localparam int NW   = $clog2(MAX_NODES);
  localparam int CNTW = $clog2(MAX_NODES + 1);
  localparam int MW   = CNTW > 7 ? CNTW : 7;
  localparam int EAW  = MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1;
  localparam int ETW  = $clog2(MAX_EDGES + 1);
  localparam int NSW  = 2 + NW + COST_W;
  localparam int NCW  = (COST_W > WEIGHT_BITS ? COST_W : WEIGHT_BITS) + 1;
  localparam int EW   = 2 * NODE_FW + WEIGHT_BITS;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_CLEAR    = 4'd1;
  localparam logic [3:0] ST_SCAN     = 4'd2;
  localparam logic [3:0] ST_R_ISSUE  = 4'd3;
  localparam logic [3:0] ST_R_EDGE   = 4'd4;
  localparam logic [3:0] ST_R_NODE   = 4'd5;
  localparam logic [3:0] ST_WALK_RD  = 4'd6;
  localparam logic [3:0] ST_WALK_DAT = 4'd7;
  localparam logic [3:0] ST_EMIT     = 4'd8;
  localparam logic [3:0] ST_DRAIN    = 4'd9;

  // registers
  logic [3:0]             state_r, state_nxt;
  logic [6:0]             nc_r, nc_nxt;
  logic [ETW-1:0]         etot_r, etot_nxt;
  logic [CNTW-1:0]        idx_r, idx_nxt;
  logic                   scan_v_r, scan_v_nxt;
  logic [NW-1:0]          scan_idx_r, scan_idx_nxt;
  logic                   best_v_r, best_v_nxt;
  logic [KEY_W-1:0]       best_key_r, best_key_nxt;
  logic [NW-1:0]          best_idx_r, best_idx_nxt;
  logic [NSW-1:0]         best_ns_r, best_ns_nxt;
  logic [NW-1:0]          start_r, start_nxt;
  logic [NW-1:0]          goal_r, goal_nxt;
  logic [ETW-1:0]         e_r, e_nxt;
  logic [NW-1:0]          nb_r, nb_nxt;
  logic [WEIGHT_BITS-1:0] w_r, w_nxt;
  logic [NW-1:0]          walk_i_r, walk_i_nxt;
  logic                   walk_v_r, walk_v_nxt;
  logic [CNTW-1:0]        cnt_r, cnt_nxt;
  logic [CNTW-1:0]        k_r, k_nxt;
  logic [CNTW-1:0]        emit_r, emit_nxt;
  logic                   pend_r, pend_nxt;
  logic                   pend_last_r, pend_last_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_r, out_nxt;

  // ram ports
  logic                   edge_we;
  logic [EAW-1:0]         edge_waddr, edge_raddr;
  logic [EW-1:0]          edge_wdata, edge_rdata;
  logic                   est_we;
  logic [NW-1:0]          est_waddr, est_raddr;
  logic [EST_W-1:0]       est_rdata;
  logic                   ns_we;
  logic [NW-1:0]          ns_waddr, ns_raddr;
  logic [NSW-1:0]         ns_wdata, ns_rdata;
  logic                   pb_we;
  logic [NW-1:0]          pb_waddr, pb_raddr;
  logic [NODE_FW-1:0]     pb_wdata, pb_rdata;

  // decoded words and shared arithmetic
  logic [MW-1:0]          n_w;
  logic                   rd_closed, rd_has_par;
  logic [NW-1:0]          rd_par;
  logic [COST_W-1:0]      rd_cost;
  logic [KEY_W-1:0]       key;
  logic [NCW-1:0]         new_cost;
  logic [NODE_FW-1:0]     eu, ev, nb6;
  logic [WEIGHT_BITS-1:0] ew;
  logic                   match_u, match_v;

  astar_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
    .raddr(edge_raddr), .rdata(edge_rdata)
  );

  astar_ram #(.WIDTH(EST_W), .DEPTH(MAX_NODES)) u_est_ram (
    .clk(clk), .we(est_we), .waddr(est_waddr), .wdata(in_data.estimate),
    .raddr(est_raddr), .rdata(est_rdata)
  );

  astar_ram #(.WIDTH(NSW), .DEPTH(MAX_NODES)) u_node_ram (
    .clk(clk), .we(ns_we), .waddr(ns_waddr), .wdata(ns_wdata),
    .raddr(ns_raddr), .rdata(ns_rdata)
  );

  astar_ram #(.WIDTH(NODE_FW), .DEPTH(MAX_NODES)) u_path_ram (
    .clk(clk), .we(pb_we), .waddr(pb_waddr), .wdata(pb_wdata),
    .raddr(pb_raddr), .rdata(pb_rdata)
  );

  assign n_w = (MW'(nc_r) > MW'(MAX_NODES)) ? MW'(MAX_NODES) : MW'(nc_r);

  // node state word: closed, has parent, parent, cost
  assign rd_closed  = ns_rdata[NSW-1];
  assign rd_has_par = ns_rdata[NSW-2];
  assign rd_par     = ns_rdata[NSW-3 -: NW];
  assign rd_cost    = ns_rdata[COST_W-1:0];

  assign key      = KEY_W'(rd_cost) + KEY_W'(est_rdata);
  assign new_cost = NCW'(best_ns_r[COST_W-1:0]) + NCW'(w_r);

  assign eu      = edge_rdata[EW-1 -: NODE_FW];
  assign ev      = edge_rdata[EW-NODE_FW-1 -: NODE_FW];
  assign ew      = edge_rdata[WEIGHT_BITS-1:0];
  assign match_u = MW'(eu) == MW'(best_idx_r);
  assign match_v = MW'(ev) == MW'(best_idx_r);
  assign nb6     = match_u ? ev : eu;

  always_comb begin
    state_nxt     = state_r;
    nc_nxt        = nc_r;
    etot_nxt      = etot_r;
    idx_nxt       = idx_r;
    scan_v_nxt    = scan_v_r;
    scan_idx_nxt  = scan_idx_r;
    best_v_nxt    = best_v_r;
    best_key_nxt  = best_key_r;
    best_idx_nxt  = best_idx_r;
    best_ns_nxt   = best_ns_r;
    start_nxt     = start_r;
    goal_nxt      = goal_r;
    e_nxt         = e_r;
    nb_nxt        = nb_r;
    w_nxt         = w_r;
    walk_i_nxt    = walk_i_r;
    walk_v_nxt    = walk_v_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    emit_nxt      = emit_r;
    pend_nxt      = 1'b0;
    pend_last_nxt = pend_last_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;

    edge_we    = 1'b0;
    edge_waddr = EAW'(etot_r);
    edge_wdata = {in_data.node_a, in_data.node_b, WEIGHT_BITS'(in_data.weight)};
    edge_raddr = EAW'(e_r);
    est_we     = 1'b0;
    est_waddr  = NW'(in_data.node_a);
    est_raddr  = NW'(idx_r);
    ns_we      = 1'b0;
    ns_waddr   = NW'(idx_r);
    ns_wdata   = {1'b0, 1'b0, NW'(0), COST_INF};
    ns_raddr   = NW'(idx_r);
    pb_we      = 1'b0;
    pb_waddr   = NW'(cnt_r);
    pb_wdata   = NODE_FW'(walk_i_r);
    pb_raddr   = NW'(cnt_r - CNTW'(1) - k_r);

    if (cfg_we) begin
      nc_nxt = cfg_wdata;
    end

    // path word from the buffer read of the previous cycle
    if (pend_r) begin
      out_valid_nxt     = 1'b1;
      out_nxt.path_node = pb_rdata;
      out_nxt.found     = 1'b1;
      out_nxt.last      = pend_last_r;
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_data.action)
            ACT_ADD_EDGE: begin
              if (etot_r < ETW'(MAX_EDGES)) begin
                edge_we  = 1'b1;
                etot_nxt = etot_r + ETW'(1);
              end
            end
            ACT_SET_EST: begin
              est_we = MW'(in_data.node_a) < MW'(MAX_NODES);
            end
            ACT_SEARCH: begin
              start_nxt = NW'(in_data.node_a);
              goal_nxt  = NW'(in_data.node_b);
              if (MW'(in_data.node_a) < n_w && MW'(in_data.node_b) < n_w) begin
                idx_nxt   = '0;
                state_nxt = ST_CLEAR;
              end else begin
                out_valid_nxt     = 1'b1;
                out_nxt.path_node = '0;
                out_nxt.found     = 1'b0;
                out_nxt.last      = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_CLEAR: begin
        ns_we = 1'b1;
        if (NW'(idx_r) == start_r) begin
          ns_wdata = {1'b0, 1'b0, NW'(0), COST_W'(0)};
        end
        idx_nxt = idx_r + CNTW'(1);
        if (MW'(idx_r) + MW'(1) == n_w) begin
          idx_nxt    = '0;
          scan_v_nxt = 1'b0;
          best_v_nxt = 1'b0;
          state_nxt  = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // consume the word read last cycle
        if (scan_v_r && !rd_closed && rd_cost != COST_INF) begin
          if (!best_v_r || key < best_key_r) begin
            best_v_nxt   = 1'b1;
            best_key_nxt = key;
            best_idx_nxt = scan_idx_r;
            best_ns_nxt  = ns_rdata;
          end
        end
        if (MW'(idx_r) < n_w) begin
          scan_v_nxt   = 1'b1;
          scan_idx_nxt = NW'(idx_r);
          idx_nxt      = idx_r + CNTW'(1);
        end else begin
          scan_v_nxt = 1'b0;
          if (!scan_v_r) begin
            if (!best_v_r) begin
              out_valid_nxt     = 1'b1;
              out_nxt.path_node = '0;
              out_nxt.found     = 1'b0;
              out_nxt.last      = 1'b1;
              state_nxt         = ST_IDLE;
            end else begin
              ns_we    = 1'b1;
              ns_waddr = best_idx_r;
              ns_wdata = {1'b1, best_ns_r[NSW-2:0]};
              if (best_idx_r == goal_r) begin
                walk_i_nxt = goal_r;
                walk_v_nxt = 1'b1;
                cnt_nxt    = '0;
                state_nxt  = ST_WALK_RD;
              end else begin
                e_nxt     = '0;
                state_nxt = ST_R_ISSUE;
              end
            end
          end
        end
      end

      ST_R_ISSUE: begin
        if (e_r < etot_r) begin
          state_nxt = ST_R_EDGE;
        end else begin
          idx_nxt    = '0;
          scan_v_nxt = 1'b0;
          best_v_nxt = 1'b0;
          state_nxt  = ST_SCAN;
        end
      end

      ST_R_EDGE: begin
        if ((match_u || match_v) && MW'(nb6) < n_w) begin
          ns_raddr  = NW'(nb6);
          nb_nxt    = NW'(nb6);
          w_nxt     = ew;
          state_nxt = ST_R_NODE;
        end else begin
          e_nxt     = e_r + ETW'(1);
          state_nxt = ST_R_ISSUE;
        end
      end

      ST_R_NODE: begin
        // cost below stored value also keeps it below infinity
        if (!rd_closed && new_cost < NCW'(rd_cost)) begin
          ns_we    = 1'b1;
          ns_waddr = nb_r;
          ns_wdata = {1'b0, 1'b1, best_idx_r, COST_W'(new_cost)};
        end
        e_nxt     = e_r + ETW'(1);
        state_nxt = ST_R_ISSUE;
      end

      ST_WALK_RD: begin
        ns_raddr = walk_i_r;
        if (walk_v_r && MW'(cnt_r) < n_w) begin
          state_nxt = ST_WALK_DAT;
        end else begin
          emit_nxt  = (MW'(cnt_r) < MW'(RESULT_LIMIT)) ? cnt_r : CNTW'(RESULT_LIMIT);
          k_nxt     = '0;
          state_nxt = ST_EMIT;
        end
      end

      ST_WALK_DAT: begin
        pb_we      = 1'b1;
        cnt_nxt    = cnt_r + CNTW'(1);
        walk_i_nxt = rd_par;
        walk_v_nxt = rd_has_par;
        state_nxt  = ST_WALK_RD;
      end

      ST_EMIT: begin
        pend_nxt      = 1'b1;
        pend_last_nxt = (k_r + CNTW'(1)) == emit_r;
        k_nxt         = k_r + CNTW'(1);
        if ((k_r + CNTW'(1)) == emit_r) begin
          state_nxt = ST_DRAIN;
        end
      end

      ST_DRAIN: begin
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      nc_r        <= 7'd64;
      etot_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nc_r        <= nc_nxt;
      etot_r      <= etot_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r       <= idx_nxt;
    scan_v_r    <= scan_v_nxt;
    scan_idx_r  <= scan_idx_nxt;
    best_v_r    <= best_v_nxt;
    best_key_r  <= best_key_nxt;
    best_idx_r  <= best_idx_nxt;
    best_ns_r   <= best_ns_nxt;
    start_r     <= start_nxt;
    goal_r      <= goal_nxt;
    e_r         <= e_nxt;
    nb_r        <= nb_nxt;
    w_r         <= w_nxt;
    walk_i_r    <= walk_i_nxt;
    walk_v_r    <= walk_v_nxt;
    cnt_r       <= cnt_nxt;
    k_r         <= k_nxt;
    emit_r      <= emit_nxt;
    pend_last_r <= pend_last_nxt;
    out_r       <= out_nxt;
  end

  assign busy      = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // every emit step leaves a buffer read in flight
  `ASTAR_ASSERT_NEXT(a_emit_pend, state_r == ST_EMIT, pend_r, "emit step lost its read")
  // a non-final word only comes out while the path drains
  `ASTAR_ASSERT_NOW(a_mid_word, out_valid_r && !out_r.last,
    state_r == ST_EMIT || state_r == ST_DRAIN, "stray path word")
  // the parent walk never stores more nodes than are in use
  `ASTAR_ASSERT_NOW(a_walk_bound, state_r == ST_WALK_DAT, MW'(cnt_r) < n_w,
    "path walk overran node count")
  `ASTAR_ASSERT_NOW(a_edge_bound, 1'b1, etot_r <= ETW'(MAX_EDGES), "edge count overflow")

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the a* path search core: loads graphs, runs searches and
// checks every path word against a behavioral predictor; depends on astar_pkg, the core
`timescale 1ns / 1ps

module tb_top;
  import astar_pkg::*;

  localparam int NODE_CAP  = 64;
  localparam int EDGE_CAP  = 256;
  localparam int NO_PARENT = -1;
  localparam longint CYCLE_LIMIT = 4000000;

  class path_scoreboard;
    int unsigned node_cnt = 64;
    int unsigned edge_total = 0;
    int unsigned edge_u[EDGE_CAP];
    int unsigned edge_v[EDGE_CAP];
    int unsigned edge_wt[EDGE_CAP];
    int unsigned est_tab[NODE_CAP];
    out_item_t   path_q[$];
    int          errors = 0;

    function void push_word(int unsigned node, bit fnd, bit lst);
      out_item_t o;
      o.path_node = node[NODE_FW-1:0];
      o.found = fnd;
      o.last = lst;
      path_q = {path_q, o};
    endfunction

    function void find_path(int unsigned src, int unsigned dst);
      int unsigned cost[NODE_CAP];
      bit          closed[NODE_CAP];
      int          par[NODE_CAP];
      int unsigned trail[NODE_CAP];
      int unsigned n, best, nb, cnt, emit, i, e;
      longint      best_key, key, nc;
      int          walk;
      n = (node_cnt > NODE_CAP) ? NODE_CAP : node_cnt;
      for (i = 0; i < NODE_CAP; i++) begin
        cost[i] = COST_INF;
        closed[i] = 0;
        par[i] = NO_PARENT;
      end
      if (src >= n || dst >= n) begin
        push_word(0, 0, 1);
        return;
      end
      cost[src] = 0;
      forever begin
        best = n;
        best_key = 0;
        for (i = 0; i < n; i++) begin
          if (!closed[i] && cost[i] < COST_INF) begin
            key = longint'(cost[i]) + est_tab[i];
            if (best == n || key < best_key) begin
              best = i;
              best_key = key;
            end
          end
        end
        if (best == n) begin
          push_word(0, 0, 1);
          return;
        end
        closed[best] = 1;
        if (best == dst) break;
        for (e = 0; e < edge_total; e++) begin
          if (edge_u[e] == best) nb = edge_v[e];
          else if (edge_v[e] == best) nb = edge_u[e];
          else continue;
          if (nb >= n || closed[nb]) continue;
          nc = longint'(cost[best]) + edge_wt[e];
          if (nc < cost[nb]) begin
            cost[nb] = nc;
            par[nb] = best;
          end
        end
      end
      cnt = 0;
      walk = dst;
      while (walk != NO_PARENT && walk < n && cnt < n) begin
        trail[cnt] = walk;
        cnt++;
        walk = par[walk];
      end
      emit = (cnt < RESULT_LIMIT) ? cnt : RESULT_LIMIT;
      for (i = 0; i < emit; i++) push_word(trail[cnt - 1 - i], 1, i + 1 == emit);
    endfunction

    function void note_word(in_item_t w);
      case (w.action)
        ACT_ADD_EDGE: begin
          if (edge_total < EDGE_CAP) begin
            edge_u[edge_total] = w.node_a;
            edge_v[edge_total] = w.node_b;
            edge_wt[edge_total] = w.weight;
            edge_total++;
          end
        end
        ACT_SET_EST: est_tab[w.node_a] = w.estimate;
        ACT_SEARCH: find_path(w.node_a, w.node_b);
        default: ;
      endcase
    endfunction

    function void check_word(out_item_t got);
      out_item_t exp_w;
      if (path_q.size() == 0) begin
        $error("path word with none pending: node %0d found %0b last %0b",
               got.path_node, got.found, got.last);
        errors++;
        return;
      end
      exp_w = path_q.pop_front();
      if (got.path_node !== exp_w.path_node) begin
        $error("path_node expected %0d actual %0d", exp_w.path_node, got.path_node);
        errors++;
      end
      if (got.found !== exp_w.found) begin
        $error("found expected %0b actual %0b", exp_w.found, got.found);
        errors++;
      end
      if (got.last !== exp_w.last) begin
        $error("last expected %0b actual %0b", exp_w.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_item_t   in_data;
  logic       out_valid;
  out_item_t  out_data;
  logic       cfg_we;
  logic [6:0] cfg_wdata;

  path_scoreboard sb;
  longint         cyc_count = 0;

  a_star_graph_path_search_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc_count <= cyc_count + 1;
    if (cyc_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && sb != null) sb.check_word(out_data);
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // word is taken at the first edge with start high and busy low
  task automatic send_word(in_item_t w, int unsigned gap);
    in_data <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_word(w);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.path_q.size() != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_count(logic [6:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.node_cnt = v;
  endtask

  function automatic in_item_t make_word(logic [1:0] act, int unsigned a, int unsigned b,
                                         int unsigned wt, int unsigned est);
    in_item_t w;
    w.action = act;
    w.node_a = a[NODE_FW-1:0];
    w.node_b = b[NODE_FW-1:0];
    w.weight = wt[15:0];
    w.estimate = est[EST_W-1:0];
    return w;
  endfunction

  function automatic in_item_t rand_word(int unsigned nc);
    int unsigned r, hi;
    hi = (nc == 0) ? 0 : ((nc > 64) ? 63 : nc - 1);
    r = $urandom_range(0, 99);
    if (r < 8) hi = 63;
    r = $urandom_range(0, 99);
    if (r < 55)
      return make_word(ACT_ADD_EDGE, $urandom_range(0, hi), $urandom_range(0, hi),
                       ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                   : $urandom_range(1, 300),
                       $urandom);
    if (r < 65)
      return make_word(ACT_SET_EST, $urandom_range(0, 63), $urandom,
                       $urandom, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 50));
    return make_word(ACT_SEARCH, $urandom_range(0, hi), $urandom_range(0, hi),
                     $urandom, $urandom);
  endfunction

  initial begin
    int unsigned counts[8] = '{8, 5, 16, 1, 64, 0, 127, 12};
    int unsigned i, k;
    sb = new();
    rst_n <= 1'b0;
    start <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // estimates must be set before any search can read them
    for (i = 0; i < NODE_CAP; i++)
      send_word(make_word(ACT_SET_EST, i, $urandom, $urandom,
                          (i == 5) ? 22'h3FFFFF : $urandom_range(0, 40)), pick_gap());

    // directed: weight extremes, self-loop, start equals goal, unreachable, unknown action
    send_word(make_word(ACT_ADD_EDGE, 0, 1, 0, 0), 0);
    send_word(make_word(ACT_ADD_EDGE, 1, 2, 16'hFFFF, 22'h3FFFFF), 0);
    send_word(make_word(ACT_ADD_EDGE, 2, 2, 7, 0), 0);
    send_word(make_word(ACT_ADD_EDGE, 0, 2, 100, 0), 1);
    send_word(make_word(ACT_ADD_EDGE, 63, 62, 1, 0), 0);
    send_word(make_word(ACT_SEARCH, 0, 2, 0, 0), 0);
    send_word(make_word(ACT_SEARCH, 1, 2, 0, 0), 0);
    send_word(make_word(ACT_SEARCH, 3, 3, 0, 0), 2);
    send_word(make_word(ACT_SEARCH, 0, 5, 0, 0), 0);
    send_word(make_word(ACT_SEARCH, 63, 62, 0, 0), 0);
    send_word(make_word(2'd3, 63, 63, 16'hFFFF, 22'h3FFFFF), 0);
    send_word(make_word(ACT_SEARCH, 2, 0, 16'hFFFF, 22'h3FFFFF), 0);
    write_count(7'd1);
    send_word(make_word(ACT_SEARCH, 0, 0, 0, 0), 0);
    send_word(make_word(ACT_SEARCH, 0, 1, 0, 0), 0);
    write_count(7'd0);
    send_word(make_word(ACT_SEARCH, 0, 0, 0, 0), 0);

    // random phases across node_count settings
    for (k = 0; k < 8; k++) begin
      write_count(7'(counts[k]));
      for (i = 0; i < 5; i++) begin
        send_word(rand_word(counts[k]), pick_gap());
        if ($urandom_range(0, 19) == 0) send_word(make_word(2'd3, $urandom, $urandom,
                                                            $urandom, $urandom), 0);
        if (i == 2 && k == 2) wait_idle();
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (sb.path_q.size() != 0 || busy) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.path_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
